>>> design/mwfd_pkg.sv
// ----------------------------------------------------------------------------
// mwfd_pkg
// Shared types and constants for the median window fire detector.
// ----------------------------------------------------------------------------
package mwfd_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RISE_THR     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_NEEDED = 2'd2;

  localparam logic [15:0] HIGH_THR_RST     = 16'd58;
  localparam logic [14:0] RISE_THR_RST     = 15'd8;
  localparam logic [4:0]  COUNT_NEEDED_RST = 5'd27;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_FIXED = 2'd1;
  localparam logic [1:0] KIND_RISE  = 2'd2;

  typedef struct packed {
    logic signed [15:0] high_thr;
    logic [14:0]        rise_thr;
    logic [4:0]         count_needed;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_EVAL   = 5'b00100,
    ST_MEDIAN = 5'b01000,
    ST_STORE  = 5'b10000
  } state_e;

endpackage

>>> design/median_window_fire_detector.sv
// ----------------------------------------------------------------------------
// median_window_fire_detector
// Median-filtered fixed-temperature and rate-of-rise heat detector.
// ----------------------------------------------------------------------------
// Flow: each word runs a scan of the smoothed RAM once the window is full, an
//   alarm check, a median rank once the raw window is full, and a store.
// Throughput: one word at a time, limited by the serial scan through the single
//   read port of the smoothed RAM and the one-entry-per-cycle median rank.
// Reset: control, fill counts and alarm clear; thresholds load 58, 8 and 27.
//   Ring contents are not cleared; fill counts keep them from being read.
module median_window_fire_detector #(
  parameter int unsigned SAMPLE_BITS  = 16,
  parameter int unsigned RAW_DEPTH    = 5,
  parameter int unsigned SMOOTH_DEPTH = 30
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // temp_sample
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,
  // alarm_latched, alarm_kind, smoothed_temp, window_full
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [((SAMPLE_BITS+4+7)/8)*8-1:0]    m_axis_tdata,
  input  logic                                  cfg_we_i,
  input  logic [mwfd_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [mwfd_pkg::CFG_DATA_W-1:0]       cfg_wdata_i
);

  localparam int unsigned OUT_W = ((SAMPLE_BITS + 4 + 7) / 8) * 8;

  mwfd_pkg::cfg_t         cfg_q;
  logic                   q_valid, q_pop;
  logic [SAMPLE_BITS-1:0] q_sample;
  logic                   out_active, out_full;
  logic [1:0]             out_kind;
  logic [SAMPLE_BITS-1:0] out_temp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.high_thr     <= mwfd_pkg::HIGH_THR_RST;
      cfg_q.rise_thr     <= mwfd_pkg::RISE_THR_RST;
      cfg_q.count_needed <= mwfd_pkg::COUNT_NEEDED_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        mwfd_pkg::CFG_HIGH_THR:     cfg_q.high_thr     <= cfg_wdata_i;
        mwfd_pkg::CFG_RISE_THR:     cfg_q.rise_thr     <= cfg_wdata_i[14:0];
        mwfd_pkg::CFG_COUNT_NEEDED: cfg_q.count_needed <= cfg_wdata_i[4:0];
        default: ;
      endcase
    end
  end

  mwfd_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_sample_i (s_axis_tdata[SAMPLE_BITS-1:0]),
    .q_valid_o   (q_valid),
    .q_sample_o  (q_sample),
    .q_pop_i     (q_pop)
  );

  mwfd_back #(
    .SAMPLE_BITS  (SAMPLE_BITS),
    .RAW_DEPTH    (RAW_DEPTH),
    .SMOOTH_DEPTH (SMOOTH_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .q_valid_i    (q_valid),
    .q_sample_i   (q_sample),
    .q_pop_o      (q_pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_active_o (out_active),
    .out_kind_o   (out_kind),
    .out_temp_o   (out_temp),
    .out_full_o   (out_full)
  );

  assign m_axis_tdata = OUT_W'({out_full, out_temp, out_kind, out_active});

  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((out_kind == mwfd_pkg::KIND_NONE) ||
                       (out_kind == mwfd_pkg::KIND_FIXED) ||
                       (out_kind == mwfd_pkg::KIND_RISE)))
    else $error("alarm kind out of range");

  a_latch_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_active == (out_kind != mwfd_pkg::KIND_NONE)))
    else $error("alarm latch and kind disagree");

  a_pop_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

endmodule

>>> design/mwfd_ram.sv
// ----------------------------------------------------------------------------
// mwfd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mwfd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 30
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/mwfd_front.sv
// ----------------------------------------------------------------------------
// mwfd_front
// Input side: accepts sample words and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module mwfd_front #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] in_sample_i,
  output logic                   q_valid_o,
  output logic [SAMPLE_BITS-1:0] q_sample_o,
  input  logic                   q_pop_i
);

  logic [SAMPLE_BITS-1:0] buf_q [2];
  logic                   wr_ptr_q, wr_ptr_d;
  logic                   rd_ptr_q, rd_ptr_d;
  logic [1:0]             count_q, count_d;
  logic                   push, pop;

  assign in_ready_o = (count_q != 2'd2);
  assign q_valid_o  = (count_q != 2'd0);
  assign q_sample_o = buf_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && q_valid_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= in_sample_i;
    end
  end

endmodule

>>> design/mwfd_back.sv
// ----------------------------------------------------------------------------
// mwfd_back
// Processing side: window scan, alarm evaluation, serial median and update.
// ----------------------------------------------------------------------------
module mwfd_back #(
  parameter int unsigned SAMPLE_BITS  = 16,
  parameter int unsigned RAW_DEPTH    = 5,
  parameter int unsigned SMOOTH_DEPTH = 30
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mwfd_pkg::cfg_t         cfg_i,
  input  logic                   q_valid_i,
  input  logic [SAMPLE_BITS-1:0] q_sample_i,
  output logic                   q_pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   out_active_o,
  output logic [1:0]             out_kind_o,
  output logic [SAMPLE_BITS-1:0] out_temp_o,
  output logic                   out_full_o
);

  localparam int unsigned SA_W  = $clog2(SMOOTH_DEPTH);
  localparam int unsigned SF_W  = $clog2(SMOOTH_DEPTH + 1);
  localparam int unsigned RCW   = $clog2(RAW_DEPTH + 1);
  localparam int unsigned WIDE  = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
  localparam int unsigned CMP_W = (SF_W > 5) ? SF_W : 5;
  localparam logic [RCW-1:0]  MED_POS  = RCW'(RAW_DEPTH / 2);
  localparam logic [RCW-1:0]  RAW_LAST = RCW'(RAW_DEPTH - 1);
  localparam logic [RCW-1:0]  RAW_CAP  = RCW'(RAW_DEPTH);
  localparam logic [SF_W-1:0] SM_CAP   = SF_W'(SMOOTH_DEPTH);
  localparam logic [SF_W-1:0] SM_LAST  = SF_W'(SMOOTH_DEPTH - 1);
  localparam logic [SA_W-1:0] PTR_LAST = SA_W'(SMOOTH_DEPTH - 1);

  mwfd_pkg::state_e state_q, state_d;

  logic signed [SAMPLE_BITS-1:0] sample_q, sample_d;
  logic signed [SAMPLE_BITS-1:0] raw_q [RAW_DEPTH];
  logic signed [SAMPLE_BITS-1:0] raw_d [RAW_DEPTH];
  logic [RCW-1:0]                raw_fill_q, raw_fill_d;
  logic [SA_W-1:0]               wr_ptr_q, wr_ptr_d;
  logic [SF_W-1:0]               sm_fill_q, sm_fill_d;
  logic [SA_W-1:0]               rd_ptr_q, rd_ptr_d;
  logic [SF_W-1:0]               iss_cnt_q, iss_cnt_d;
  logic [SF_W-1:0]               proc_cnt_q, proc_cnt_d;
  logic                          dv_q, dv_d;
  logic [SF_W-1:0]               hit_cnt_q, hit_cnt_d;
  logic signed [SAMPLE_BITS-1:0] oldest_q, oldest_d;
  logic signed [SAMPLE_BITS-1:0] last_med_q, last_med_d;
  logic signed [SAMPLE_BITS-1:0] median_q, median_d;
  logic [RCW-1:0]                med_cnt_q, med_cnt_d;
  logic                          latch_q, latch_d;
  logic [1:0]                    cause_q, cause_d;
  logic                          out_valid_q, out_valid_d;
  logic                          out_act_q, out_act_d;
  logic [1:0]                    out_kind_q, out_kind_d;
  logic [SAMPLE_BITS-1:0]        out_temp_q, out_temp_d;
  logic                          out_full_q, out_full_d;

  logic                          ram_we, ram_re;
  logic [SAMPLE_BITS-1:0]        ram_rdata;
  logic signed [SAMPLE_BITS-1:0] rd_entry;
  logic signed [WIDE-1:0]        entry_ext, thr_ext;
  logic signed [WIDE:0]          rise_diff, rise_ext;
  logic                          fixed_hit, rise_hit;
  logic [RCW-1:0]                n_less, n_eq;
  logic                          raw_full, sm_full, out_free;

  mwfd_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (SMOOTH_DEPTH)
  ) u_smooth_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (median_q),
    .re_i    (ram_re),
    .raddr_i (rd_ptr_q),
    .rdata_o (ram_rdata)
  );

  assign raw_full  = (raw_fill_q == RAW_CAP);
  assign sm_full   = (sm_fill_q == SM_CAP);
  assign out_free  = !out_valid_q || out_ready_i;
  assign rd_entry  = $signed(ram_rdata);
  assign entry_ext = WIDE'(rd_entry);
  assign thr_ext   = WIDE'(cfg_i.high_thr);
  assign rise_diff = (WIDE + 1)'(last_med_q) - (WIDE + 1)'(oldest_q);
  assign rise_ext  = $signed((WIDE + 1)'(cfg_i.rise_thr));
  assign fixed_hit = CMP_W'(hit_cnt_q) >= CMP_W'(cfg_i.count_needed);
  assign rise_hit  = rise_diff >= rise_ext;

  assign q_pop_o = (state_q == mwfd_pkg::ST_IDLE) && q_valid_i;
  assign ram_re  = (state_q == mwfd_pkg::ST_SCAN) && (iss_cnt_q != SM_CAP);
  assign ram_we  = (state_q == mwfd_pkg::ST_STORE) && out_free && raw_full;

  // rank of raw_q[0] within the raw window
  always_comb begin
    n_less = '0;
    n_eq   = '0;
    for (int j = 0; j < RAW_DEPTH; j++) begin
      n_less = n_less + RCW'(raw_q[j] < raw_q[0]);
      n_eq   = n_eq + RCW'(raw_q[j] == raw_q[0]);
    end
  end

  always_comb begin
    state_d     = state_q;
    sample_d    = sample_q;
    raw_d       = raw_q;
    raw_fill_d  = raw_fill_q;
    wr_ptr_d    = wr_ptr_q;
    sm_fill_d   = sm_fill_q;
    rd_ptr_d    = rd_ptr_q;
    iss_cnt_d   = iss_cnt_q;
    proc_cnt_d  = proc_cnt_q;
    dv_d        = 1'b0;
    hit_cnt_d   = hit_cnt_q;
    oldest_d    = oldest_q;
    last_med_d  = last_med_q;
    median_d    = median_q;
    med_cnt_d   = med_cnt_q;
    latch_d     = latch_q;
    cause_d     = cause_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_act_d   = out_act_q;
    out_kind_d  = out_kind_q;
    out_temp_d  = out_temp_q;
    out_full_d  = out_full_q;

    case (state_q)
      mwfd_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          sample_d   = $signed(q_sample_i);
          rd_ptr_d   = wr_ptr_q;
          iss_cnt_d  = '0;
          proc_cnt_d = '0;
          hit_cnt_d  = '0;
          med_cnt_d  = '0;
          if (sm_full) begin
            state_d = mwfd_pkg::ST_SCAN;
          end else if (raw_full) begin
            state_d = mwfd_pkg::ST_MEDIAN;
          end else begin
            state_d = mwfd_pkg::ST_STORE;
          end
        end
      end
      mwfd_pkg::ST_SCAN: begin
        // reads issued oldest first; data returns in the next cycle
        if (ram_re) begin
          rd_ptr_d  = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + SA_W'(1);
          iss_cnt_d = iss_cnt_q + SF_W'(1);
          dv_d      = 1'b1;
        end
        if (dv_q) begin
          if (proc_cnt_q == '0) begin
            oldest_d = rd_entry;
          end
          if (entry_ext >= thr_ext) begin
            hit_cnt_d = hit_cnt_q + SF_W'(1);
          end
          proc_cnt_d = proc_cnt_q + SF_W'(1);
          if (proc_cnt_q == SM_LAST) begin
            state_d = mwfd_pkg::ST_EVAL;
          end
        end
      end
      mwfd_pkg::ST_EVAL: begin
        if (fixed_hit) begin
          latch_d = 1'b1;
          cause_d = mwfd_pkg::KIND_FIXED;
        end
        if (rise_hit) begin
          latch_d = 1'b1;
          cause_d = mwfd_pkg::KIND_RISE;
        end
        state_d = raw_full ? mwfd_pkg::ST_MEDIAN : mwfd_pkg::ST_STORE;
      end
      mwfd_pkg::ST_MEDIAN: begin
        // rotate the window, testing the head entry for the median rank
        if ((n_less <= MED_POS) && (MED_POS < n_less + n_eq)) begin
          median_d = raw_q[0];
        end
        for (int i = 0; i < RAW_DEPTH; i++) begin
          raw_d[i] = raw_q[(i + 1) % RAW_DEPTH];
        end
        med_cnt_d = med_cnt_q + RCW'(1);
        if (med_cnt_q == RAW_LAST) begin
          state_d = mwfd_pkg::ST_STORE;
        end
      end
      mwfd_pkg::ST_STORE: begin
        if (out_free) begin
          if (raw_full) begin
            last_med_d = median_q;
            wr_ptr_d   = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + SA_W'(1);
            if (!sm_full) begin
              sm_fill_d = sm_fill_q + SF_W'(1);
            end
          end
          raw_d[0] = sample_q;
          for (int i = 1; i < RAW_DEPTH; i++) begin
            raw_d[i] = raw_q[i - 1];
          end
          if (!raw_full) begin
            raw_fill_d = raw_fill_q + RCW'(1);
          end
          out_valid_d = 1'b1;
          out_act_d   = latch_q;
          out_kind_d  = cause_q;
          out_temp_d  = last_med_d;
          out_full_d  = (sm_fill_d == SM_CAP);
          state_d     = mwfd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mwfd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mwfd_pkg::ST_IDLE;
      raw_fill_q  <= '0;
      wr_ptr_q    <= '0;
      sm_fill_q   <= '0;
      rd_ptr_q    <= '0;
      iss_cnt_q   <= '0;
      proc_cnt_q  <= '0;
      dv_q        <= 1'b0;
      hit_cnt_q   <= '0;
      last_med_q  <= '0;
      med_cnt_q   <= '0;
      latch_q     <= 1'b0;
      cause_q     <= mwfd_pkg::KIND_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      raw_fill_q  <= raw_fill_d;
      wr_ptr_q    <= wr_ptr_d;
      sm_fill_q   <= sm_fill_d;
      rd_ptr_q    <= rd_ptr_d;
      iss_cnt_q   <= iss_cnt_d;
      proc_cnt_q  <= proc_cnt_d;
      dv_q        <= dv_d;
      hit_cnt_q   <= hit_cnt_d;
      last_med_q  <= last_med_d;
      med_cnt_q   <= med_cnt_d;
      latch_q     <= latch_d;
      cause_q     <= cause_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q   <= sample_d;
    raw_q      <= raw_d;
    oldest_q   <= oldest_d;
    median_q   <= median_d;
    out_act_q  <= out_act_d;
    out_kind_q <= out_kind_d;
    out_temp_q <= out_temp_d;
    out_full_q <= out_full_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_active_o = out_act_q;
  assign out_kind_o   = out_kind_q;
  assign out_temp_o   = out_temp_q;
  assign out_full_o   = out_full_q;

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for median_window_fire_detector. Temperature words go
// in on the slave stream. A mirror of the raw and smoothed rings and of the
// alarm latch predicts every output word, and each word leaving the master
// stream is checked field by field. A short table of directed words runs
// first: field extremes, every threshold and count corner, and both alarms
// in one step. Random segments of slow drifts, ramps, noise and extreme
// values follow, with register changes between segments. Both stream sides
// idle in random bursts, except near the end of the run.
// ----------------------------------------------------------------------------
module testbench;
  import mwfd_pkg::*;

  localparam int RAW_N       = 5;
  localparam int SMOOTH_N    = 30;
  localparam int RAND_ITEMS  = 1450;
  localparam int QUIET_ITEMS = 200;
  localparam int TAIL_CYCLES = 60;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic               wf;
    logic signed [15:0] smoothed;
    logic [1:0]         kind;
    logic               active;
  } report_t;

  typedef struct packed {
    bit                 is_reg;
    logic [1:0]         reg_idx;
    logic [15:0]        reg_val;
    logic signed [15:0] smp;
    logic [7:0]         reps;
    bit                 typed;
    report_t            want;
  } plan_row_t;

  localparam report_t NO_ALARM = '0;

  localparam int PLAN_N = 30;
  localparam plan_row_t PLAN [PLAN_N] = '{
    '{1'b0, CFG_HIGH_THR, 16'h0000, 16'h7FFF, 8'd1, 1'b1, NO_ALARM},
    '{1'b0, CFG_HIGH_THR, 16'h0000, 16'h7FFF, 8'd1, 1'b1, NO_ALARM},
    '{1'b0, CFG_HIGH_THR, 16'h0000, 16'h7FFF, 8'd1, 1'b1, NO_ALARM},
    '{1'b0, CFG_HIGH_THR, 16'h0000, 16'h8000, 8'd1, 1'b1, NO_ALARM},
    '{1'b0, CFG_HIGH_THR, 16'h0000, 16'h8000, 8'd1, 1'b1, NO_ALARM},
    '{1'b0, CFG_HIGH_THR, 16'h0000, 16'h0000, 8'd1, 1'b1,
      '{1'b0, 16'h7FFF, KIND_NONE, 1'b0}},
    '{1'b0, CFG_HIGH_THR, 16'h0000, 16'h0000, 8'd1, 1'b1, NO_ALARM},
    '{1'b0, CFG_HIGH_THR, 16'h0000, 16'h0064, 8'd40, 1'b0, NO_ALARM},
    // count zero: fixed alarm on every full window
    '{1'b1, CFG_COUNT_NEEDED, 16'h0000, 16'h0000, 8'd0, 1'b0, NO_ALARM},
    '{1'b1, CFG_RISE_THR, 16'hFFFF, 16'h0000, 8'd0, 1'b0, NO_ALARM},
    '{1'b0, CFG_HIGH_THR, 16'h0000, 16'h0064, 8'd3, 1'b0, NO_ALARM},
    // count above window: never fires, latch holds
    '{1'b1, CFG_COUNT_NEEDED, 16'hFFFF, 16'h0000, 8'd0, 1'b0, NO_ALARM},
    '{1'b1, CFG_HIGH_THR, 16'h8000, 16'h0000, 8'd0, 1'b0, NO_ALARM},
    '{1'b0, CFG_HIGH_THR, 16'h0000, 16'h0064, 8'd3, 1'b0, NO_ALARM},
    '{1'b1, CFG_COUNT_NEEDED, 16'h001E, 16'h0000, 8'd0, 1'b0, NO_ALARM},
    '{1'b0, CFG_HIGH_THR, 16'h0000, 16'h0064, 8'd3, 1'b0, NO_ALARM},
    // both alarms in one step
    '{1'b1, CFG_RISE_THR, 16'h0000, 16'h0000, 8'd0, 1'b0, NO_ALARM},
    '{1'b0, CFG_HIGH_THR, 16'h0000, 16'h0064, 8'd3, 1'b0, NO_ALARM},
    '{1'b1, CFG_UNUSED, 16'hFFFF, 16'h0000, 8'd0, 1'b0, NO_ALARM},
    // full-scale rise, must not wrap
    '{1'b1, CFG_HIGH_THR, 16'h7FFF, 16'h0000, 8'd0, 1'b0, NO_ALARM},
    '{1'b1, CFG_RISE_THR, 16'h7FFF, 16'h0000, 8'd0, 1'b0, NO_ALARM},
    '{1'b1, CFG_COUNT_NEEDED, 16'h001F, 16'h0000, 8'd0, 1'b0, NO_ALARM},
    '{1'b0, CFG_HIGH_THR, 16'h0000, 16'h8000, 8'd36, 1'b0, NO_ALARM},
    '{1'b0, CFG_HIGH_THR, 16'h0000, 16'h7FFF, 8'd4, 1'b0, NO_ALARM},
    '{1'b1, CFG_COUNT_NEEDED, 16'h0001, 16'h0000, 8'd0, 1'b0, NO_ALARM},
    '{1'b0, CFG_HIGH_THR, 16'h0000, 16'h7FFF, 8'd3, 1'b0, NO_ALARM},
    '{1'b1, CFG_HIGH_THR, 16'h003A, 16'h0000, 8'd0, 1'b0, NO_ALARM},
    '{1'b1, CFG_RISE_THR, 16'h0008, 16'h0000, 8'd0, 1'b0, NO_ALARM},
    '{1'b1, CFG_COUNT_NEEDED, 16'h001B, 16'h0000, 8'd0, 1'b0, NO_ALARM},
    '{1'b0, CFG_HIGH_THR, 16'h0000, 16'hFFFF, 8'd6, 1'b0, NO_ALARM}
  };

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata  = '0;  // temp_sample
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // alarm_latched, alarm_kind, smoothed_temp, window_full, zero pad
  logic [23:0]           m_axis_tdata;
  logic                  cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i   = '0;

  median_window_fire_detector uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // detector mirror
  logic signed [15:0] raw_win    [RAW_N]    = '{default: '0};
  logic signed [15:0] smooth_win [SMOOTH_N] = '{default: '0};
  int                 raw_wr     = 0;
  int                 raw_cnt    = 0;
  int                 smooth_wr  = 0;
  int                 smooth_cnt = 0;
  logic               alarm_on   = 1'b0;
  logic [1:0]         alarm_why  = KIND_NONE;
  cfg_t               cfg_m      = '{HIGH_THR_RST, RISE_THR_RST, COUNT_NEEDED_RST};

  report_t expected_reports [$];
  int      errs  = 0;
  bit      quiet = 1'b0;

  function automatic report_t predict_report(input logic signed [15:0] smp);
    int                 hits;
    int                 newest;
    int                 oldest;
    logic signed [15:0] srt [RAW_N];
    logic signed [15:0] tmp;
    report_t            r;
    if (smooth_cnt >= SMOOTH_N) begin
      hits = 0;
      for (int i = 0; i < SMOOTH_N; i++)
        if (smooth_win[i] >= $signed(cfg_m.high_thr)) hits++;
      oldest = smooth_win[smooth_wr];
      newest = smooth_win[(smooth_wr + SMOOTH_N - 1) % SMOOTH_N];
      if (hits >= int'(cfg_m.count_needed)) begin
        alarm_on  = 1'b1;
        alarm_why = KIND_FIXED;
      end
      if (newest - oldest >= int'(cfg_m.rise_thr)) begin
        alarm_on  = 1'b1;
        alarm_why = KIND_RISE;
      end
    end
    if (raw_cnt >= RAW_N) begin
      srt = raw_win;
      for (int i = 0; i < RAW_N - 1; i++)
        for (int j = 0; j < RAW_N - 1 - i; j++)
          if (srt[j] > srt[j+1]) begin
            tmp      = srt[j];
            srt[j]   = srt[j+1];
            srt[j+1] = tmp;
          end
      smooth_win[smooth_wr] = srt[RAW_N/2];
      smooth_wr = (smooth_wr + 1) % SMOOTH_N;
      if (smooth_cnt < SMOOTH_N) smooth_cnt++;
    end
    raw_win[raw_wr] = smp;
    raw_wr = (raw_wr + 1) % RAW_N;
    if (raw_cnt < RAW_N) raw_cnt++;
    r.active   = alarm_on;
    r.kind     = alarm_why;
    r.smoothed = smooth_win[(smooth_wr + SMOOTH_N - 1) % SMOOTH_N];
    r.wf       = (smooth_cnt >= SMOOTH_N);
    return r;
  endfunction

  task automatic send_temp(input logic signed [15:0] smp, input bit typed,
                           input report_t want);
    report_t calc;
    s_axis_tdata  <= smp;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    calc = predict_report(smp);
    expected_reports.push_back(typed ? want : calc);
    if (!quiet && $urandom_range(0, 2) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  // only with the block drained
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    s_axis_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_HIGH_THR:     cfg_m.high_thr     = val;
      CFG_RISE_THR:     cfg_m.rise_thr     = val[14:0];
      CFG_COUNT_NEEDED: cfg_m.count_needed = val[4:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  initial begin : drain
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_reports
    report_t got;
    report_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[19:0];
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected word, expected none got %h", $time, m_axis_tdata);
        errs++;
      end else begin
        want = expected_reports.pop_front();
        if (got.active !== want.active) begin
          $display("%0t: alarm latch expected %0d got %0d", $time, want.active, got.active);
          errs++;
        end
        if (got.kind !== want.kind) begin
          $display("%0t: alarm_kind expected %0d got %0d", $time, want.kind, got.kind);
          errs++;
        end
        if (got.smoothed !== want.smoothed) begin
          $display("%0t: smoothed_temp expected %0d got %0d", $time,
                   want.smoothed, got.smoothed);
          errs++;
        end
        if (got.wf !== want.wf) begin
          $display("%0t: window_full expected %0d got %0d", $time, want.wf, got.wf);
          errs++;
        end
        if (m_axis_tdata[23:20] !== 4'h0) begin
          $display("%0t: pad bits expected 0 got %h", $time, m_axis_tdata[23:20]);
          errs++;
        end
      end
    end
  end

  initial begin : stimulus
    int                 done_n;
    int                 seg_len;
    int                 mode;
    int                 lvl;
    int                 reg_sel;
    logic [15:0]        v;
    logic signed [15:0] smp;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < PLAN_N; r++) begin
      if (PLAN[r].is_reg)
        write_reg(PLAN[r].reg_idx, PLAN[r].reg_val);
      else
        repeat (PLAN[r].reps) send_temp(PLAN[r].smp, PLAN[r].typed, PLAN[r].want);
    end

    done_n = 0;
    while (done_n < RAND_ITEMS) begin
      if ($urandom_range(0, 1) == 1) begin
        repeat ($urandom_range(1, 3)) begin
          reg_sel = $urandom_range(0, 9);
          v = 16'($urandom);
          if (reg_sel < 3) begin
            case ($urandom_range(0, 3))
              0: v = 16'h8000;
              1: v = 16'h7FFF;
              2: v = 16'($urandom_range(0, 160)) - 16'd80;
              default: ;
            endcase
            write_reg(CFG_HIGH_THR, v);
          end else if (reg_sel < 6) begin
            case ($urandom_range(0, 3))
              0: v = 16'h0000;
              1: v = 16'hFFFF;
              2: v = (v & 16'h8000) | 16'($urandom_range(0, 40));
              default: ;
            endcase
            write_reg(CFG_RISE_THR, v);
          end else if (reg_sel < 9) begin
            case ($urandom_range(0, 3))
              0: v[4:0] = 5'd0;
              1: v[4:0] = 5'd30;
              2: v[4:0] = 5'd31;
              default: v[4:0] = 5'($urandom_range(0, 31));
            endcase
            write_reg(CFG_COUNT_NEEDED, v);
          end else begin
            write_reg(CFG_UNUSED, v);
          end
        end
      end

      seg_len = $urandom_range(20, 120);
      mode    = $urandom_range(0, 9);
      lvl     = int'($signed(cfg_m.high_thr)) + int'($urandom_range(0, 80)) - 40;
      for (int k = 0; k < seg_len && done_n < RAND_ITEMS; k++) begin
        quiet = (done_n >= RAND_ITEMS - QUIET_ITEMS);
        case (mode)
          6, 7: smp = 16'($urandom);
          8: begin
            case ($urandom_range(0, 3))
              0: smp = 16'h7FFF;
              1: smp = 16'h8000;
              2: smp = 16'h0000;
              default: smp = 16'hFFFF;
            endcase
          end
          9: begin
            lvl += int'($urandom_range(0, 40));
            if (lvl > 32767) lvl = 32767;
            smp = lvl[15:0];
          end
          default: begin
            // slow drift with jumps and lone spikes
            if ($urandom_range(0, 29) == 0) lvl += int'($urandom_range(0, 400)) - 100;
            lvl += int'($urandom_range(0, 8)) - 3;
            if (lvl > 32767) lvl = 32767;
            if (lvl < -32768) lvl = -32768;
            smp = ($urandom_range(0, 19) == 0) ? 16'($urandom) : lvl[15:0];
          end
        endcase
        send_temp(smp, 1'b0, NO_ALARM);
        done_n++;
      end
    end

    s_axis_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (errs == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin : watchdog
    #8_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

>>> filelist.f
design/mwfd_pkg.sv
design/mwfd_ram.sv
design/mwfd_front.sv
design/mwfd_back.sv
design/median_window_fire_detector.sv
tb/testbench.sv
